/* design/svc_pkg.sv */
package svc_pkg;

  localparam int DW         = 32;
  localparam int DIV_STAGES = 32;
  localparam int FRAC_SHIFT = 12;
  localparam int CFG_DW     = 31;
  localparam int CFG_AW     = 3;

  localparam logic [CFG_AW-1:0] CFG_WIN_W    = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_WIN_H    = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_SCALE_X  = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_SCALE_Y  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_PERSP_N  = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_PERSP_OF = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_DOT_N    = 3'd6;
  localparam logic [CFG_AW-1:0] CFG_DOT_LIM  = 3'd7;

  typedef struct packed {
    logic signed [23:0] rel_x;
    logic signed [23:0] rel_y;
    logic signed [23:0] rel_z;
    logic [15:0]        sphere_radius;
  } svc_in_t;

  typedef struct packed {
    logic               visible;
    logic               is_dot;
    logic signed [19:0] proj_size;
    logic [12:0]        dot_px;
    logic [12:0]        dot_py;
    logic               clipped;
  } svc_out_t;

  typedef struct packed {
    logic [12:0] window_width;
    logic [12:0] window_height;
    logic [8:0]  scale_x;
    logic [8:0]  scale_y;
    logic [30:0] persp_numerator;
    logic [15:0] persp_offset;
    logic [15:0] dot_numerator;
    logic [7:0]  dot_limit;
  } svc_cfg_t;

endpackage

/* design/sphere_view_cull_unit.sv */
// Bounding-sphere view test. Each item (view-relative x/y/z and radius) gives
// one result: projected size, dot/box decision, dot screen position and a clip
// flag for boxes that cross a window edge. The pipeline has one input stage,
// 32 stages of the radix-2 pipelined dividers (four of them, one per
// quotient), and four stages of multiply and window compare. One item enters
// per cycle; a stall on the output holds the whole pipeline in place.
// Configuration writes are applied at once and must only be issued while idle.
module sphere_view_cull_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  svc_pkg::svc_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output svc_pkg::svc_out_t          out_data,
  input  logic                       cfg_we,
  input  logic [svc_pkg::CFG_AW-1:0] cfg_index,
  input  logic [svc_pkg::CFG_DW-1:0] cfg_data
);
  import svc_pkg::*;

  svc_cfg_t cfg;
  logic     en;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_width    <= 13'd320;
      cfg.window_height   <= 13'd240;
      cfg.scale_x         <= 9'd256;
      cfg.scale_y         <= 9'd256;
      cfg.persp_numerator <= 31'd65536;
      cfg.persp_offset    <= 16'd256;
      cfg.dot_numerator   <= 16'd256;
      cfg.dot_limit       <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIN_W:    cfg.window_width    <= cfg_data[12:0];
        CFG_WIN_H:    cfg.window_height   <= cfg_data[12:0];
        CFG_SCALE_X:  cfg.scale_x         <= cfg_data[8:0];
        CFG_SCALE_Y:  cfg.scale_y         <= cfg_data[8:0];
        CFG_PERSP_N:  cfg.persp_numerator <= cfg_data[30:0];
        CFG_PERSP_OF: cfg.persp_offset    <= cfg_data[15:0];
        CFG_DOT_N:    cfg.dot_numerator   <= cfg_data[15:0];
        CFG_DOT_LIM:  cfg.dot_limit       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input stage: divisors and dot numerators
  logic [DW-1:0] tx_in, ty_in, tz_in, p_raw, pn_raw;
  logic          v0;
  logic [DW-1:0] p0, pn0, nx0, ny0, tx0, ty0;
  logic [15:0]   r0;

  assign tx_in  = DW'(in_data.rel_x);
  assign ty_in  = DW'(in_data.rel_y);
  assign tz_in  = DW'(in_data.rel_z);
  assign p_raw  = tz_in + {16'd0, cfg.persp_offset};
  assign pn_raw = p_raw - {16'd0, in_data.sphere_radius};

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0  <= (p_raw == '0) ? DW'(1) : p_raw;
      pn0 <= (pn_raw == '0) ? DW'(1) : pn_raw;
      nx0 <= tx_in * {16'd0, cfg.dot_numerator};
      ny0 <= ty_in * {16'd0, cfg.dot_numerator};
      tx0 <= tx_in;
      ty0 <= ty_in;
      r0  <= in_data.sphere_radius;
    end
  end

  logic [DW-1:0] num;
  logic [DW-1:0] q_scale, q_near, q_x, q_y;

  assign num = {1'b0, cfg.persp_numerator};

  svc_div u_div_scale (.clk, .en, .dividend(num), .divisor(p0),  .quotient(q_scale));
  svc_div u_div_near  (.clk, .en, .dividend(num), .divisor(pn0), .quotient(q_near));
  svc_div u_div_x     (.clk, .en, .dividend(nx0), .divisor(p0),  .quotient(q_x));
  svc_div u_div_y     (.clk, .en, .dividend(ny0), .divisor(p0),  .quotient(q_y));

  // side data riding along the divider stages
  logic          sv  [DIV_STAGES];
  logic [DW-1:0] stx [DIV_STAGES];
  logic [DW-1:0] sty [DIV_STAGES];
  logic [15:0]   sr  [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_STAGES; i++) sv[i] <= 1'b0;
    end else if (en) begin
      sv[0] <= v0;
      for (int i = 1; i < DIV_STAGES; i++) sv[i] <= sv[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stx[0] <= tx0;
      sty[0] <= ty0;
      sr[0]  <= r0;
      for (int i = 1; i < DIV_STAGES; i++) begin
        stx[i] <= stx[i-1];
        sty[i] <= sty[i-1];
        sr[i]  <= sr[i-1];
      end
    end
  end

  svc_box u_box (
    .clk,
    .rst,
    .en,
    .cfg,
    .in_valid (sv[DIV_STAGES-1]),
    .scale_a  (q_scale),
    .scale_b  (q_near),
    .quot_x   (q_x),
    .quot_y   (q_y),
    .tx       (stx[DIV_STAGES-1]),
    .ty       (sty[DIV_STAGES-1]),
    .radius   (sr[DIV_STAGES-1]),
    .out_valid,
    .out_data
  );

endmodule

/* design/svc_div.sv */
module svc_div (
  input  logic                 clk,
  input  logic                 en,
  input  logic [svc_pkg::DW-1:0] dividend,
  input  logic [svc_pkg::DW-1:0] divisor,
  output logic [svc_pkg::DW-1:0] quotient
);
  import svc_pkg::*;

  logic [DW-1:0] rem [DIV_STAGES];
  logic [DW-1:0] dvd [DIV_STAGES];
  logic [DW-1:0] quo [DIV_STAGES];
  logic [DW-1:0] dsr [DIV_STAGES];
  logic          neg [DIV_STAGES];

  logic [DW-1:0] mag_a;
  logic [DW-1:0] mag_b_raw;
  logic [DW-1:0] mag_b;

  assign mag_a     = dividend[DW-1] ? (~dividend + 1'b1) : dividend;
  assign mag_b_raw = divisor[DW-1] ? (~divisor + 1'b1) : divisor;
  assign mag_b     = (mag_b_raw == '0) ? DW'(1) : mag_b_raw;

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [DW-1:0] r_in, d_in, q_in, s_in;
    logic          n_in;
    logic [DW:0]   remw;
    logic [DW+1:0] trial;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign d_in = mag_a;
      assign q_in = '0;
      assign s_in = mag_b;
      assign n_in = dividend[DW-1] ^ divisor[DW-1];
    end else begin : g_next
      assign r_in = rem[k-1];
      assign d_in = dvd[k-1];
      assign q_in = quo[k-1];
      assign s_in = dsr[k-1];
      assign n_in = neg[k-1];
    end

    assign remw  = {r_in, d_in[DW-1]};
    assign trial = {1'b0, remw} - {2'b00, s_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= trial[DW+1] ? remw[DW-1:0] : trial[DW-1:0];
        dvd[k] <= {d_in[DW-2:0], 1'b0};
        quo[k] <= {q_in[DW-2:0], ~trial[DW+1]};
        dsr[k] <= s_in;
        neg[k] <= n_in;
      end
    end
  end

  assign quotient = neg[DIV_STAGES-1] ? (~quo[DIV_STAGES-1] + 1'b1) : quo[DIV_STAGES-1];

endmodule

/* design/svc_box.sv */
module svc_box (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  svc_pkg::svc_cfg_t      cfg,
  input  logic                   in_valid,
  input  logic [svc_pkg::DW-1:0] scale_a,
  input  logic [svc_pkg::DW-1:0] scale_b,
  input  logic [svc_pkg::DW-1:0] quot_x,
  input  logic [svc_pkg::DW-1:0] quot_y,
  input  logic [svc_pkg::DW-1:0] tx,
  input  logic [svc_pkg::DW-1:0] ty,
  input  logic [15:0]            radius,
  output logic                   out_valid,
  output svc_pkg::svc_out_t      out_data
);
  import svc_pkg::*;

  // stage 1: quotients registered
  logic          v1;
  logic [DW-1:0] sa1, sb1, qx1, qy1, tx1, ty1;
  logic [15:0]   r1;
  // stage 2: products with scale
  logic          v2;
  logic [DW-1:0] x2, y2, scal2, scaln2, qx2, qy2;
  // stage 3: half extents
  logic          v3;
  logic [DW-1:0] size3, s1_3, s2_3, s1n3, s2n3, x3, y3, qx3, qy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa1 <= scale_a;
      sb1 <= scale_b;
      qx1 <= DW'($signed(quot_x) >>> 1);
      qy1 <= DW'($signed(quot_y) >>> 1);
      tx1 <= tx;
      ty1 <= ty;
      r1  <= radius;

      x2     <= tx1 * sa1;
      y2     <= ty1 * sa1;
      scal2  <= {16'd0, r1} * sa1;
      scaln2 <= {16'd0, r1} * sb1;
      qx2    <= qx1;
      qy2    <= qy1;

      size3 <= DW'($signed(scal2) >>> FRAC_SHIFT);
      s1_3  <= DW'($signed(scal2 * {23'd0, cfg.scale_x}) >>> 8);
      s2_3  <= DW'($signed(scal2 * {23'd0, cfg.scale_y}) >>> 8);
      s1n3  <= DW'($signed(scaln2 * {23'd0, cfg.scale_x}) >>> 8);
      s2n3  <= DW'($signed(scaln2 * {23'd0, cfg.scale_y}) >>> 8);
      x3    <= x2;
      y3    <= y2;
      qx3   <= qx2;
      qy3   <= qy2;
    end
  end

  // stage 4: window tests
  logic signed [DW-1:0] hw, hh, nhw, nhh;
  logic signed [DW-1:0] lft, rgt, top, bot, lftn, rgtn, topn, botn;
  logic                 dot, dot_vis, box_vis, clip;
  svc_out_t             res;

  assign hw  = $signed({20'd0, cfg.window_width[12:1]});
  assign hh  = $signed({20'd0, cfg.window_height[12:1]});
  assign nhw = -hw;
  assign nhh = -hh;

  assign lft  = $signed(x3 - s1_3) >>> FRAC_SHIFT;
  assign rgt  = $signed(x3 + s1_3) >>> FRAC_SHIFT;
  assign top  = $signed(y3 + s2_3) >>> FRAC_SHIFT;
  assign bot  = $signed(y3 - s2_3) >>> FRAC_SHIFT;
  assign lftn = $signed(x3 - s1n3) >>> FRAC_SHIFT;
  assign rgtn = $signed(x3 + s1n3) >>> FRAC_SHIFT;
  assign topn = $signed(y3 + s2n3) >>> FRAC_SHIFT;
  assign botn = $signed(y3 - s2n3) >>> FRAC_SHIFT;

  assign dot     = $signed(size3) < $signed({24'd0, cfg.dot_limit});
  assign dot_vis = ($signed(qx3) >= nhw) && ($signed(qx3) <= hw) &&
                   ($signed(qy3) >= nhh) && ($signed(qy3) <= hh);
  assign box_vis = (lft < hw) && (nhw < rgt) && (nhh < top) && (bot < hh);
  // box re-measured at the near face of the sphere
  assign clip    = (rgtn >= hw) || (lftn < nhw) || (botn <= nhh) || (topn > hh);

  always_comb begin
    res           = '0;
    res.is_dot    = dot;
    res.proj_size = size3[19:0];
    if (dot) begin
      res.visible = dot_vis;
      if (dot_vis) begin
        res.dot_px = 13'(qx3 + DW'(hw));
        res.dot_py = 13'(qy3 + DW'(hh));
      end
    end else begin
      res.visible = box_vis;
      res.clipped = box_vis && clip;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res;
    end
  end

`ifndef SYNTH
  a_clip_box: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.clipped |-> out_data.visible && !out_data.is_dot)
    else $error("clipped set on a dot or hidden item");
  a_screen_dot: assert property (@(posedge clk) disable iff (rst)
    out_valid && !(out_data.visible && out_data.is_dot) |->
      out_data.dot_px == 13'd0 && out_data.dot_py == 13'd0)
    else $error("screen position set outside a visible dot");
  a_valid_chain: assert property (@(posedge clk) disable iff (rst)
    en && v3 |=> out_valid)
    else $error("valid lost in the last stage");
`endif

endmodule
